// ----- src/dgt_pkg.sv -----
// Package for the depth grid triangulator: widths, reset values, codes and state types.
`timescale 1ns / 1ps

package dgt_pkg;

  // Defaults for the top-level parameters
  localparam int DefMaxRowWidth = 1024;
  localparam int DefCoordBits   = 24;

  // Fixed field widths
  localparam int RowIdxW        = 10;
  localparam int ColIdxW        = 10;
  localparam int DimW           = 11;
  localparam int NearW          = 23;
  localparam int CosW           = 16;
  localparam int CosSqW         = 2 * CosW;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 23;
  localparam int MaxFrameHeight = 1024;

  // Register reset values
  localparam logic [DimW-1:0]  RstRowWidth    = DimW'(800);
  localparam logic [DimW-1:0]  RstFrameHeight = DimW'(600);
  localparam logic [NearW-1:0] RstNear        = NearW'(65536);
  localparam logic [CosW-1:0]  RstCos         = CosW'(11380);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_NEAR         = 2'd2,
    CFG_COS          = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_RUN,
    ST_STORE,
    ST_FINISH
  } state_t;

  // Multiply steps of one face test, in execution order
  typedef enum logic [3:0] {
    OP_AYBZ,
    OP_AZBY,
    OP_AZBX,
    OP_AXBZ,
    OP_AXBY,
    OP_AYBX,
    OP_NX2,
    OP_NY2,
    OP_NZ2,
    OP_T2,
    OP_RHS
  } op_t;

endpackage

// ----- src/depth_grid_triangulator_top.sv -----
// Each item is accepted in ST_IDLE and passes ST_READ, then, for each triangle that is
// tested, ST_LOAD, ST_RUN and ST_STORE for each multiply step, and at last ST_FINISH.
// Items are taken one at a time; the shared shift-add multiplier runs eleven products
// per tested triangle, one multiplier bit per cycle.
// Reset (synchronous, active low) loads register defaults and clears counters and the
// left/upper-left pixels; the previous-row memory is not cleared.
`timescale 1ns / 1ps

module depth_grid_triangulator_top import dgt_pkg::*; #(
  parameter int MAX_ROW_WIDTH = DefMaxRowWidth,
  parameter int COORD_BITS    = DefCoordBits
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [CfgIdxW-1:0]           cfg_index,
  input  logic [CfgDataW-1:0]          cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [RowIdxW-1:0]           out_row_index,
  output logic [ColIdxW-1:0]           out_column_index,
  output logic                         out_vertex_removed,
  output logic                         out_faces_present,
  output logic                         out_upper_face_kept,
  output logic                         out_lower_face_kept,
  output logic                         out_frame_last
);

  localparam int ColW  = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int LimW  = (ColW + 2 > DimW + 1) ? ColW + 2 : DimW + 1;
  localparam int HgtW  = DimW + 1;
  localparam int DB    = COORD_BITS + 1;
  localparam int NB    = 2 * DB + 1;
  localparam int NnW   = 2 * NB + 2;
  localparam int AccW  = NnW + CosSqW;
  localparam int CntW  = $clog2(NB + 1);
  localparam int ZcW   = ((COORD_BITS > NearW) ? COORD_BITS : NearW) + 2;
  localparam int MemW  = 3 * COORD_BITS + 1;

  // Configuration registers
  logic [DimW-1:0]  cfg_row_width_r, cfg_frame_height_r;
  logic [NearW-1:0] cfg_near_r;
  logic [CosW-1:0]  cfg_cos_r;

  // Sequencer
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   face_r, face_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Pixel state
  logic [ColW-1:0]    column_count_r;
  logic [RowIdxW-1:0] row_count_r;
  logic signed [COORD_BITS-1:0] cur_r[3], up_r[3], left_r[3], upleft_r[3];
  logic cur_rm_r, up_rm_r, left_rm_r, upleft_rm_r;
  logic faces_r, eval_l_r, upper_kept_r, lower_kept_r;

  // Previous-row memory
  logic [MemW-1:0] mem_r [MAX_ROW_WIDTH];
  logic [MemW-1:0] rd_data_r;

  // Multiplier and cross-product registers
  logic [AccW-1:0]      mul_a_r, acc_r;
  logic [NB-1:0]        mul_b_r;
  logic [CntW-1:0]      cnt_r;
  logic                 neg_r;
  logic signed [NB-1:0] p_r, nx_r, ny_r, nz_r;
  logic [NnW-1:0]       nn_r;
  logic [2*NB-1:0]      nz2_r;
  logic [CosSqW-1:0]    t2_r;

  // Output registers
  logic [RowIdxW-1:0] out_row_r;
  logic [ColIdxW-1:0] out_col_r;
  logic out_rm_r, out_faces_r, out_upper_r, out_lower_r, out_last_r;

  logic in_acc, finish_go;

  function automatic logic [DB-1:0] abs_d(input logic signed [DB-1:0] v);
    abs_d = v[DB-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [NB-1:0] abs_n(input logic signed [NB-1:0] v);
    abs_n = v[NB-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // Near plane test on the incoming z
  logic signed [ZcW-1:0] z_ext, near_neg;
  logic in_rm;
  always_comb begin
    z_ext    = $signed({{(ZcW-COORD_BITS){in_pos_z[COORD_BITS-1]}}, in_pos_z});
    near_neg = -$signed({{(ZcW-NearW){1'b0}}, cfg_near_r});
    in_rm    = z_ext > near_neg;
  end

  // Clamped row width and frame height, end-of-row and end-of-frame
  logic [LimW-1:0] w_lim;
  logic [HgtW-1:0] h_lim;
  logic col_end, row_end;
  always_comb begin
    w_lim = LimW'(cfg_row_width_r);
    if (w_lim < LimW'(2)) w_lim = LimW'(2);
    if (w_lim > LimW'(MAX_ROW_WIDTH)) w_lim = LimW'(MAX_ROW_WIDTH);
    h_lim = HgtW'(cfg_frame_height_r);
    if (h_lim < HgtW'(2)) h_lim = HgtW'(2);
    if (h_lim > HgtW'(MaxFrameHeight)) h_lim = HgtW'(MaxFrameHeight);
    col_end = (LimW'(column_count_r) + LimW'(1)) >= w_lim;
    row_end = (HgtW'(row_count_r) + HgtW'(1)) >= h_lim;
  end

  // Flags from the previous-row read
  logic rd_rm, faces_c, eval_u_c, eval_l_c;
  always_comb begin
    rd_rm    = rd_data_r[MemW-1];
    faces_c  = (row_count_r != '0) && (column_count_r != '0);
    eval_u_c = faces_c && !(upleft_rm_r || rd_rm || cur_rm_r);
    eval_l_c = faces_c && !(upleft_rm_r || left_rm_r || cur_rm_r);
  end

  // Edge vectors of the face under test: a = A - B, b = C - B
  logic signed [DB-1:0] da[3], db[3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!face_r) begin
        da[k] = $signed({upleft_r[k][COORD_BITS-1], upleft_r[k]})
              - $signed({up_r[k][COORD_BITS-1], up_r[k]});
        db[k] = $signed({cur_r[k][COORD_BITS-1], cur_r[k]})
              - $signed({up_r[k][COORD_BITS-1], up_r[k]});
      end else begin
        da[k] = $signed({cur_r[k][COORD_BITS-1], cur_r[k]})
              - $signed({left_r[k][COORD_BITS-1], left_r[k]});
        db[k] = $signed({upleft_r[k][COORD_BITS-1], upleft_r[k]})
              - $signed({left_r[k][COORD_BITS-1], left_r[k]});
      end
    end
  end

  // Operand selection for the next multiply step
  logic signed [DB-1:0] sx, sy;
  logic [AccW-1:0] ld_a;
  logic [NB-1:0]   ld_b;
  logic [CntW-1:0] ld_len;
  logic            ld_neg;
  always_comb begin
    sx = '0;
    sy = '0;
    case (op_r)
      OP_AYBZ: begin sx = da[1]; sy = db[2]; end
      OP_AZBY: begin sx = da[2]; sy = db[1]; end
      OP_AZBX: begin sx = da[2]; sy = db[0]; end
      OP_AXBZ: begin sx = da[0]; sy = db[2]; end
      OP_AXBY: begin sx = da[0]; sy = db[1]; end
      OP_AYBX: begin sx = da[1]; sy = db[0]; end
      default: begin sx = '0; sy = '0; end
    endcase
    ld_a   = AccW'(abs_d(sx));
    ld_b   = NB'(abs_d(sy));
    ld_len = CntW'(DB);
    ld_neg = sx[DB-1] ^ sy[DB-1];
    case (op_r)
      OP_NX2: begin
        ld_a = AccW'(abs_n(nx_r)); ld_b = abs_n(nx_r); ld_len = CntW'(NB); ld_neg = 1'b0;
      end
      OP_NY2: begin
        ld_a = AccW'(abs_n(ny_r)); ld_b = abs_n(ny_r); ld_len = CntW'(NB); ld_neg = 1'b0;
      end
      OP_NZ2: begin
        ld_a = AccW'(abs_n(nz_r)); ld_b = abs_n(nz_r); ld_len = CntW'(NB); ld_neg = 1'b0;
      end
      OP_T2: begin
        ld_a = AccW'(cfg_cos_r); ld_b = NB'(cfg_cos_r); ld_len = CntW'(CosW); ld_neg = 1'b0;
      end
      OP_RHS: begin
        ld_a = AccW'(nn_r); ld_b = NB'(t2_r); ld_len = CntW'(CosSqW); ld_neg = 1'b0;
      end
      default: ;
    endcase
  end

  // Signed product and tilt comparison
  logic signed [NB-1:0] prod_s;
  logic [AccW-1:0] lhs;
  logic kept_c;
  always_comb begin
    prod_s = neg_r ? -$signed(acc_r[NB-1:0]) : $signed(acc_r[NB-1:0]);
    lhs    = AccW'(nz2_r) << CosSqW;
    kept_c = lhs >= acc_r;
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    face_nxt      = face_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_READ;
      end
      ST_READ: begin
        op_nxt = OP_AYBZ;
        if (eval_u_c) begin
          face_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end else if (eval_l_c) begin
          face_nxt  = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_LOAD: state_nxt = ST_RUN;
      ST_RUN: begin
        if (cnt_r == CntW'(1)) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        if (op_r == OP_RHS) begin
          op_nxt = OP_AYBZ;
          if (!face_r && eval_l_r) begin
            face_nxt  = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else begin
          op_nxt    = op_t'(op_r + 1'b1);
          state_nxt = ST_LOAD;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers, configuration and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      op_r               <= OP_AYBZ;
      face_r             <= 1'b0;
      out_valid_r        <= 1'b0;
      cfg_row_width_r    <= RstRowWidth;
      cfg_frame_height_r <= RstFrameHeight;
      cfg_near_r         <= RstNear;
      cfg_cos_r          <= RstCos;
      column_count_r     <= '0;
      row_count_r        <= '0;
      left_rm_r          <= 1'b0;
      upleft_rm_r        <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        left_r[k]   <= '0;
        upleft_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      face_r      <= face_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ROW_WIDTH:    cfg_row_width_r    <= cfg_wdata[DimW-1:0];
          CFG_FRAME_HEIGHT: cfg_frame_height_r <= cfg_wdata[DimW-1:0];
          CFG_NEAR:         cfg_near_r         <= cfg_wdata[NearW-1:0];
          CFG_COS:          cfg_cos_r          <= cfg_wdata[CosW-1:0];
          default: ;
        endcase
      end
      if (finish_go) begin
        for (int k = 0; k < 3; k++) begin
          upleft_r[k] <= up_r[k];
          left_r[k]   <= cur_r[k];
        end
        upleft_rm_r <= up_rm_r;
        left_rm_r   <= cur_rm_r;
        if (col_end) begin
          column_count_r <= '0;
          row_count_r    <= row_end ? '0 : row_count_r + 1'b1;
        end else begin
          column_count_r <= column_count_r + 1'b1;
        end
      end
    end
  end

  // Previous-row memory: read on accept, write back the current pixel in the following cycle
  always_ff @(posedge clk) begin
    if (in_acc) rd_data_r <= mem_r[column_count_r];
    if (state_r == ST_READ) mem_r[column_count_r] <= {cur_rm_r, cur_r[2], cur_r[1], cur_r[0]};
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r[0] <= in_pos_x;
      cur_r[1] <= in_pos_y;
      cur_r[2] <= in_pos_z;
      cur_rm_r <= in_rm;
    end
    case (state_r)
      ST_READ: begin
        up_r[0]      <= rd_data_r[COORD_BITS-1:0];
        up_r[1]      <= rd_data_r[2*COORD_BITS-1:COORD_BITS];
        up_r[2]      <= rd_data_r[3*COORD_BITS-1:2*COORD_BITS];
        up_rm_r      <= rd_rm;
        faces_r      <= faces_c;
        eval_l_r     <= eval_l_c;
        upper_kept_r <= 1'b0;
        lower_kept_r <= 1'b0;
      end
      ST_LOAD: begin
        mul_a_r <= ld_a;
        mul_b_r <= ld_b;
        cnt_r   <= ld_len;
        neg_r   <= ld_neg;
        acc_r   <= '0;
      end
      ST_RUN: begin
        // one multiplier bit per cycle
        if (mul_b_r[0]) acc_r <= acc_r + mul_a_r;
        mul_a_r <= mul_a_r << 1;
        mul_b_r <= mul_b_r >> 1;
        cnt_r   <= cnt_r - 1'b1;
      end
      ST_STORE: begin
        case (op_r) inside
          OP_AYBZ, OP_AZBX, OP_AXBY: p_r <= prod_s;
          OP_AZBY: nx_r <= p_r - prod_s;
          OP_AXBZ: ny_r <= p_r - prod_s;
          OP_AYBX: nz_r <= p_r - prod_s;
          OP_NX2:  nn_r <= NnW'(acc_r);
          OP_NY2:  nn_r <= nn_r + NnW'(acc_r);
          OP_NZ2: begin
            nz2_r <= acc_r[2*NB-1:0];
            nn_r  <= nn_r + NnW'(acc_r);
          end
          OP_T2:   t2_r <= acc_r[CosSqW-1:0];
          OP_RHS: begin
            if (face_r) lower_kept_r <= kept_c;
            else        upper_kept_r <= kept_c;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (finish_go) begin
      out_row_r   <= row_count_r;
      out_col_r   <= ColIdxW'(column_count_r);
      out_rm_r    <= cur_rm_r;
      out_faces_r <= faces_r;
      out_upper_r <= upper_kept_r;
      out_lower_r <= lower_kept_r;
      out_last_r  <= col_end && row_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row_index       = out_row_r;
  assign out_column_index    = out_col_r;
  assign out_vertex_removed  = out_rm_r;
  assign out_faces_present   = out_faces_r;
  assign out_upper_face_kept = out_upper_r;
  assign out_lower_face_kept = out_lower_r;
  assign out_frame_last      = out_last_r;

`ifndef SYNTH
  // A new result only appears from the finishing step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside the finishing step");

  // Without faces no triangle may be reported kept
  a_no_face_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_faces_present) |-> (!out_upper_face_kept && !out_lower_face_kept))
    else $error("triangle kept on a pixel without faces");

  // The multiplier never runs with an exhausted bit count
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r != '0))
    else $error("multiplier running with zero count");
`endif

endmodule

// ----- bench/depth_grid_triangulator_top_tb.sv -----
// Self-checking testbench for depth_grid_triangulator_top: directed and random rasters.
`timescale 1ns / 1ps

module depth_grid_triangulator_top_tb;
  import dgt_pkg::*;

  localparam int CoordW  = DefCoordBits;
  localparam int MaxRowW = DefMaxRowWidth;

  typedef logic signed [199:0] wide_t;
  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } pix_t;
  typedef struct {
    int unsigned row;
    int unsigned col;
    bit removed;
    bit faces;
    bit upper;
    bit lower;
    bit last;
  } tri_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [CoordW-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic out_valid;
  logic out_stall;
  logic [RowIdxW-1:0] out_row_index;
  logic [ColIdxW-1:0] out_column_index;
  logic out_vertex_removed, out_faces_present, out_upper_face_kept;
  logic out_lower_face_kept, out_frame_last;

  depth_grid_triangulator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row_index(out_row_index), .out_column_index(out_column_index),
    .out_vertex_removed(out_vertex_removed), .out_faces_present(out_faces_present),
    .out_upper_face_kept(out_upper_face_kept), .out_lower_face_kept(out_lower_face_kept),
    .out_frame_last(out_frame_last)
  );

  // Shadow registers and mesh state
  logic [DimW-1:0] row_width_sh, frame_height_sh;
  logic [NearW-1:0] near_sh;
  logic [CosW-1:0] cos_sh;
  pix_t prev_row[MaxRowW];
  bit prev_rm[MaxRowW];
  pix_t left_pix, upleft_pix;
  bit left_rm, upleft_rm;
  int unsigned col_cnt, row_cnt;

  pix_t pixel_q[$];
  tri_res_t mesh_q[$];
  int send_idle_pct, stall_pct, hold_req, hold_cnt, fails;
  int noise, grid_step;
  bit took;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Tilt test, exact: nz^2 * 2^32 >= T^2 * |n|^2 keeps the face
  function automatic bit face_ok(pix_t a, pix_t b, pix_t c);
    wide_t ax, ay, az, bx, by, bz, nx, ny, nz, nn, lhs, rhs, t;
    ax = wide_t'(a.x) - wide_t'(b.x);
    ay = wide_t'(a.y) - wide_t'(b.y);
    az = wide_t'(a.z) - wide_t'(b.z);
    bx = wide_t'(c.x) - wide_t'(b.x);
    by = wide_t'(c.y) - wide_t'(b.y);
    bz = wide_t'(c.z) - wide_t'(b.z);
    nx = ay * bz - az * by;
    ny = az * bx - ax * bz;
    nz = ax * by - ay * bx;
    nn = nx * nx + ny * ny + nz * nz;
    t = wide_t'({1'b0, cos_sh});
    lhs = (nz * nz) <<< 32;
    rhs = t * t * nn;
    return !(lhs < rhs);
  endfunction

  function automatic int unsigned eff_width();
    return row_width_sh < 2 ? 2 : (row_width_sh > MaxRowW ? MaxRowW : row_width_sh);
  endfunction

  function automatic int unsigned eff_height();
    return frame_height_sh < 2 ? 2 :
           (frame_height_sh > MaxFrameHeight ? MaxFrameHeight : frame_height_sh);
  endfunction

  // Advance the mesh state by one pixel and queue its expected result
  task automatic triangulate(input pix_t cur);
    int unsigned w, h, col, row;
    pix_t up;
    bit up_rm, cur_rm;
    tri_res_t r;
    w = eff_width();
    h = eff_height();
    col = col_cnt % MaxRowW;
    row = row_cnt;
    cur_rm = longint'(cur.z) > -longint'(near_sh);
    up = prev_row[col];
    up_rm = prev_rm[col];
    r.row = row & 10'h3ff;
    r.col = col & 10'h3ff;
    r.removed = cur_rm;
    r.faces = (row != 0) && (col != 0);
    r.upper = r.faces && !(upleft_rm || up_rm || cur_rm) && face_ok(upleft_pix, up, cur);
    r.lower = r.faces && !(upleft_rm || left_rm || cur_rm) && face_ok(cur, left_pix, upleft_pix);
    r.last = (col + 1 >= w) && (row + 1 >= h);
    prev_row[col] = cur;
    prev_rm[col] = cur_rm;
    upleft_pix = up;
    upleft_rm = up_rm;
    left_pix = cur;
    left_rm = cur_rm;
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
    mesh_q.push_back(r);
  endtask

  // Pixels left until the current frame ends (state must be settled)
  function automatic int frame_remaining();
    int unsigned c, r, w, h;
    int n;
    bit done;
    c = col_cnt % MaxRowW;
    r = row_cnt;
    w = eff_width();
    h = eff_height();
    n = 0;
    done = 0;
    while (!done) begin
      n++;
      done = (c + 1 >= w) && (r + 1 >= h);
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
    end
    return n;
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(longint v);
    if (v < -(longint'(1) << (CoordW - 1))) return {1'b1, {(CoordW-1){1'b0}}};
    if (v > (longint'(1) << (CoordW - 1)) - 1) return {1'b0, {(CoordW-1){1'b1}}};
    return v[CoordW-1:0];
  endfunction

  // Mostly a noisy surface in front of the near plane, some raw noise
  function automatic pix_t make_pixel(int unsigned idx);
    pix_t p;
    int unsigned c;
    c = idx % eff_width();
    if ($urandom_range(0, 9) < 7) begin
      p.x = clamp_coord(longint'(c) * grid_step + $urandom_range(0, noise) - noise / 2);
      p.y = clamp_coord(longint'(idx / eff_width()) * grid_step
                        + $urandom_range(0, noise) - noise / 2);
    end else begin
      p.x = CoordW'($urandom);
      p.y = CoordW'($urandom);
    end
    if ($urandom_range(0, 9) < 8)
      p.z = clamp_coord(-longint'(near_sh) - $urandom_range(0, noise));
    else
      p.z = CoordW'($urandom);
    return p;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ROW_WIDTH:    row_width_sh = val[DimW-1:0];
      CFG_FRAME_HEIGHT: frame_height_sh = val[DimW-1:0];
      CFG_NEAR:         near_sh = val[NearW-1:0];
      CFG_COS:          cos_sh = val[CosW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && mesh_q.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic queue_pixels(input int n);
    for (int i = 0; i < n; i++) pixel_q.push_back(make_pixel(i));
  endtask

  function automatic pix_t mk(longint x, longint y, longint z);
    pix_t p;
    p.x = clamp_coord(x);
    p.y = clamp_coord(y);
    p.z = clamp_coord(z);
    return p;
  endfunction

  // Input driver: new item at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      took = 1'b0;
      if (pixel_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_pos_x <= pixel_q[0].x;
        in_pos_y <= pixel_q[0].y;
        in_pos_z <= pixel_q[0].z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      triangulate(pixel_q.pop_front());
      took = 1'b1;
    end
  end

  // Receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // Result monitor
  always @(posedge clk) begin
    tri_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (mesh_q.size() == 0) begin
        $error("unexpected result item at row %0d column %0d", out_row_index, out_column_index);
        fails++;
      end else begin
        e = mesh_q.pop_front();
        check_field("row_index", e.row, out_row_index);
        check_field("column_index", e.col, out_column_index);
        check_field("vertex_removed", e.removed, out_vertex_removed);
        check_field("faces_present", e.faces, out_faces_present);
        check_field("upper_face_kept", e.upper, out_upper_face_kept);
        check_field("lower_face_kept", e.lower, out_lower_face_kept);
        check_field("frame_last", e.last, out_frame_last);
      end
    end
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    longint mx, mn;
    int idle_tab[4][2];
    int n;
    idle_tab = '{'{0, 0}, '{69, 0}, '{0, 69}, '{21, 21}};
    mx = (longint'(1) << (CoordW - 1)) - 1;
    mn = -(longint'(1) << (CoordW - 1));
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROW_WIDTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    out_stall = 1'b0;
    took = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    fails = 0;
    noise = 4096;
    grid_step = 65536;
    row_width_sh = RstRowWidth;
    frame_height_sh = RstFrameHeight;
    near_sh = RstNear;
    cos_sh = RstCos;
    col_cnt = 0;
    row_cnt = 0;
    left_pix = mk(0, 0, 0);
    upleft_pix = mk(0, 0, 0);
    left_rm = 0;
    upleft_rm = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: 3x3 frames with extreme coordinates, a degenerate frame, near edge
    write_reg(CFG_ROW_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    write_reg(CFG_NEAR, 65536);
    write_reg(CFG_COS, 11380);
    pixel_q.push_back(mk(mn, mn, mn));
    pixel_q.push_back(mk(mx, mn, mn));
    pixel_q.push_back(mk(mx, mx, mn));
    pixel_q.push_back(mk(mn, mx, -65536));
    pixel_q.push_back(mk(mx, mx, mx));
    pixel_q.push_back(mk(mn, mx, mn));
    pixel_q.push_back(mk(0, mn, mn));
    pixel_q.push_back(mk(mn, 0, -mx));
    pixel_q.push_back(mk(mx, 0, mn));
    for (int i = 0; i < 9; i++)
      pixel_q.push_back(mk(-77, 123, (i == 4) ? -65535 : -65536));
    drain();

    // Width beyond range acts as the maximum; shrink mid-frame afterwards
    write_reg(CFG_ROW_WIDTH, 2047);
    write_reg(CFG_FRAME_HEIGHT, 2);
    write_reg(CFG_NEAR, 0);
    write_reg(CFG_COS, 65535);
    queue_pixels(40);
    drain();
    write_reg(CFG_ROW_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    queue_pixels(frame_remaining());
    drain();

    // Tall frame beyond range, then the height cut short mid-frame
    write_reg(CFG_ROW_WIDTH, 2);
    write_reg(CFG_FRAME_HEIGHT, 2047);
    write_reg(CFG_NEAR, {NearW{1'b1}});
    write_reg(CFG_COS, 0);
    queue_pixels(30);
    drain();
    write_reg(CFG_FRAME_HEIGHT, 3);
    queue_pixels(frame_remaining());
    drain();

    // Random phases with whole frames
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      send_idle_pct = idle_tab[ph % 4][0];
      stall_pct = idle_tab[ph % 4][1];
      write_reg(CFG_ROW_WIDTH, CfgDataW'($urandom_range(2, 12)));
      write_reg(CFG_FRAME_HEIGHT, CfgDataW'($urandom_range(2, 10)));
      write_reg(CFG_NEAR, ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(0, 8388607))
                                                        : CfgDataW'($urandom_range(0, 200000)));
      write_reg(CFG_COS, ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(0, 65535))
                                                       : CfgDataW'($urandom_range(5000, 60000)));
      noise = 1 << $urandom_range(4, 22);
      grid_step = $urandom_range(1, 1 << 18);
      if (ph == 4) hold_req = 3000;
      n = 0;
      while (n < 100) begin
        n += frame_remaining();
        queue_pixels(frame_remaining());
        wait (pixel_q.size() == 0);
      end
    end

    drain();
    repeat (800) @(posedge clk);
    if (fails == 0 && mesh_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
